// ----- hw/rtl/pfla_pkg.sv -----
// Shared types and constants for the page free-list allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps

package pfla_pkg;

   // Field widths fixed by the operation and result formats
   localparam int IdxWidth        = 12;
   localparam int StatusWidth     = 2;
   localparam int CountWidth      = 13;
   localparam int DefaultNumPages = 4096;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_NOT_HELD = 2'd2
   } status_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_step;   // write one held bit of the reset sweep
      logic accept;       // latch the request and launch memory reads
      logic commit;       // apply the operation and load the response register
   } pfla_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;   // sweep is at its final entry
      logic out_free;     // response register can take a new response
   } pfla_stat_type;

endpackage

// ----- hw/rtl/pfla_req_if.sv -----
// Request channel: valid/ready handshake carrying one allocator operation.
// Depends on pfla_pkg for field widths.
`timescale 1ns / 1ps

interface pfla_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [pfla_pkg::IdxWidth-1:0] page_index;

   modport source (output valid, output opcode, output page_index, input ready);
   modport sink   (input valid, input opcode, input page_index, output ready);
endinterface

// ----- hw/rtl/pfla_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one allocator result.
// Depends on pfla_pkg for field widths.
`timescale 1ns / 1ps

interface pfla_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pfla_pkg::StatusWidth-1:0] status;
   logic [pfla_pkg::IdxWidth-1:0]    granted_page;
   logic [pfla_pkg::CountWidth-1:0]  free_pages;

   modport source (output valid, output status, output granted_page, output free_pages,
                   input ready);
   modport sink   (input valid, input status, input granted_page, input free_pages,
                   output ready);
endinterface

// ----- hw/rtl/pfla_ctrl.sv -----
// Controller state machine: reset sweep, request acceptance and commit sequencing.
// Depends on pfla_pkg for the command and status structs.
`timescale 1ns / 1ps

module pfla_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pfla_pkg::pfla_stat_type stat,
   output pfla_pkg::pfla_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Decode commands from the current state
   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      cmd.clear_step  = (state_ff == ST_CLEAR);
      cmd.accept      = (state_ff == ST_IDLE) && req_valid;
      cmd.commit      = (state_ff == ST_EXEC) && stat.out_free;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            // hold until the response register is free
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/pfla_datapath.sv -----
// Datapath: free-list and held-bit memories, head/tail/count registers, response register.
// Depends on pfla_pkg; driven by pfla_ctrl commands.
`timescale 1ns / 1ps

module pfla_datapath #(
   parameter int NUM_PAGES = pfla_pkg::DefaultNumPages
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pfla_pkg::pfla_cmd_type           cmd,
   output pfla_pkg::pfla_stat_type          stat,
   input  logic                             req_opcode,
   input  logic [pfla_pkg::IdxWidth-1:0]    req_page_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pfla_pkg::StatusWidth-1:0] rsp_status,
   output logic [pfla_pkg::IdxWidth-1:0]    rsp_granted_page,
   output logic [pfla_pkg::CountWidth-1:0]  rsp_free_pages
);

   localparam int IW = pfla_pkg::IdxWidth;
   localparam int NW = pfla_pkg::CountWidth;
   localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int CW = ((AW > IW) ? AW : IW) + 2;
   localparam logic [AW-1:0] LastSlot = AW'(NUM_PAGES - 1);
   localparam logic [CW-1:0] PoolSize = CW'(NUM_PAGES);

   // Memories
   logic          held_mem  [NUM_PAGES];
   logic [IW-1:0] queue_mem [NUM_PAGES];

   // Control registers
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [NW-1:0] count_ff, count_in;
   logic [AW-1:0] clear_cnt_ff;
   logic          rsp_valid_ff;

   // Latched request and registered read data
   pfla_pkg::opcode_type op_ff;
   logic [IW-1:0]        idx_ff;
   logic                 idx_ok_ff;
   logic                 held_rd_ff;
   logic [IW-1:0]        queue_rd_ff;

   // Response payload
   pfla_pkg::status_type status_ff, status_in;
   logic [IW-1:0]        granted_ff, granted_in;
   logic [NW-1:0]        free_ff;

   // Memory write controls
   logic          held_we;
   logic [AW-1:0] held_waddr;
   logic          held_wdata;
   logic          queue_we;
   logic          page_ok;

   assign stat.clear_last = (clear_cnt_ff == LastSlot);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign page_ok = (CW'(queue_rd_ff) < PoolSize);

   // Work out the operation result and memory writes
   always_comb begin
      status_in  = pfla_pkg::STATUS_OK;
      granted_in = '0;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      held_we    = cmd.clear_step;
      held_waddr = clear_cnt_ff;
      held_wdata = 1'b1;
      queue_we   = 1'b0;
      if (cmd.commit) begin
         if (op_ff == pfla_pkg::OP_ALLOC) begin
            if (count_ff == '0) begin
               status_in = pfla_pkg::STATUS_EMPTY;
            end else begin
               granted_in = queue_rd_ff;
               head_in    = (head_ff == LastSlot) ? '0 : head_ff + AW'(1);
               count_in   = count_ff - NW'(1);
               held_we    = page_ok;
               held_waddr = AW'(queue_rd_ff);
               held_wdata = 1'b1;
            end
         end else begin
            if (!idx_ok_ff || !held_rd_ff) begin
               status_in = pfla_pkg::STATUS_NOT_HELD;
            end else begin
               held_we    = 1'b1;
               held_waddr = AW'(idx_ff);
               held_wdata = 1'b0;
               queue_we   = 1'b1;
               tail_in    = (tail_ff == LastSlot) ? '0 : tail_ff + AW'(1);
               count_in   = count_ff + NW'(1);
            end
         end
      end
   end

   // Held-bit memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (held_we) begin
         held_mem[held_waddr] <= held_wdata;
      end
      if (cmd.accept) begin
         held_rd_ff <= held_mem[AW'(req_page_index)];
      end
   end

   // Free-list memory: append at tail, read at head
   always_ff @(posedge clock) begin
      if (queue_we) begin
         queue_mem[tail_ff] <= idx_ff;
      end
      if (cmd.accept) begin
         queue_rd_ff <= queue_mem[head_ff];
      end
   end

   // Latch request and load response payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= pfla_pkg::opcode_type'(req_opcode);
         idx_ff    <= req_page_index;
         idx_ok_ff <= (CW'(req_page_index) < PoolSize);
      end
      if (cmd.commit) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         free_ff    <= count_in;
      end
   end

   // Pointers, count, sweep counter and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (cmd.clear_step) begin
            clear_cnt_ff <= clear_cnt_ff + AW'(1);
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_granted_page = granted_ff;
   assign rsp_free_pages   = free_ff;

endmodule

// ----- hw/rtl/page_free_list_allocator_core.sv -----
// Page free-list allocator: hands out and takes back fixed-size pages.
//
// Channels: req_ch carries one operation per request (opcode 0 allocate,
// 1 free page_index); rsp_ch returns exactly one response per request with
// status, granted_page and the number of free pages after the operation.
// Both use valid/ready; a transfer happens on a clock edge with both high.
//
// Timing: a request is taken in ST_IDLE, then committed from ST_EXEC once the
// response register is free; the response appears the cycle after commit.
// No request is taken before the last commits: the held-bit and free-list
// memories, each with a single port per direction, are read then written.
// A stalled response holds in the output register; one more request may be
// taken meanwhile, and its commit waits until the register is drained.
//
// Reset (synchronous, active high): the free list empties and a sweep of
// all NUM_PAGES entries (4096 by default) marks every page held; req_ch.ready
// stays low during it. Software then fills the pool by freeing pages.
// Depends on pfla_pkg, pfla_req_if, pfla_rsp_if, pfla_ctrl and pfla_datapath.
`timescale 1ns / 1ps

module page_free_list_allocator_core #(
   parameter int NUM_PAGES = pfla_pkg::DefaultNumPages
) (
   input logic        clock,
   input logic        reset,
   pfla_req_if.sink   req_ch,
   pfla_rsp_if.source rsp_ch
);

   pfla_pkg::pfla_cmd_type  cmd;
   pfla_pkg::pfla_stat_type stat;

   // Sequence sweep, accept and commit
   pfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold memories, pointers and the response register
   pfla_datapath #(
      .NUM_PAGES (NUM_PAGES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_ch.opcode),
      .req_page_index   (req_ch.page_index),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_status       (rsp_ch.status),
      .rsp_granted_page (rsp_ch.granted_page),
      .rsp_free_pages   (rsp_ch.free_pages)
   );

endmodule

// ----- tb/sv/page_free_list_allocator_core_tb.sv -----
// Self-checking bench for the page free-list allocator core: directed rows, then
// random allocate/free traffic with idle bursts, then a bulk fill and drain pass.
// Depends on pfla_pkg, pfla_req_if, pfla_rsp_if and page_free_list_allocator_core.
`timescale 1ns / 1ps

module page_free_list_allocator_core_tb;

   localparam int IdxWidth     = pfla_pkg::IdxWidth;
   localparam int CountWidth   = pfla_pkg::CountWidth;
   localparam int NUM_PAGES    = pfla_pkg::DefaultNumPages;
   localparam int RANDOM_OPS   = 900;
   localparam int FINAL_FREES  = 200;
   localparam int DIRECTED_OPS = 19;

   typedef struct packed {
      pfla_pkg::status_type  status;
      logic [IdxWidth-1:0]   granted_page;
      logic [CountWidth-1:0] free_pages;
   } alloc_rsp_type;

   typedef struct {
      pfla_pkg::opcode_type op;
      logic [IdxWidth-1:0]  idx;
      bit                   typed;   // response typed in below, else predicted
      alloc_rsp_type        rsp;
   } dir_row_type;

   logic clock;
   logic reset;

   pfla_req_if req_ch();
   pfla_rsp_if rsp_ch();

   page_free_list_allocator_core #(
      .NUM_PAGES(NUM_PAGES)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Shadow of the allocator state
   logic [IdxWidth-1:0] list_slots [NUM_PAGES];
   bit                  page_held  [NUM_PAGES];
   int                  list_head;
   int                  list_tail;
   int                  free_total;

   alloc_rsp_type pending_outcomes[$];
   int            mismatch_count = 0;
   int            stall_left = 0;
   bit            quiet = 1'b1;

   // Directed rows: empty list, double free, extreme indexes, ignored index on allocate
   dir_row_type directed_rows [DIRECTED_OPS] = '{
      '{pfla_pkg::OP_ALLOC, 12'd0,    1'b1, '{pfla_pkg::STATUS_EMPTY,    12'd0,    13'd0}},
      '{pfla_pkg::OP_ALLOC, 12'd4095, 1'b1, '{pfla_pkg::STATUS_EMPTY,    12'd0,    13'd0}},
      '{pfla_pkg::OP_FREE,  12'd0,    1'b1, '{pfla_pkg::STATUS_OK,       12'd0,    13'd1}},
      '{pfla_pkg::OP_FREE,  12'd0,    1'b1, '{pfla_pkg::STATUS_NOT_HELD, 12'd0,    13'd1}},
      '{pfla_pkg::OP_FREE,  12'd4095, 1'b1, '{pfla_pkg::STATUS_OK,       12'd0,    13'd2}},
      '{pfla_pkg::OP_FREE,  12'd4095, 1'b1, '{pfla_pkg::STATUS_NOT_HELD, 12'd0,    13'd2}},
      '{pfla_pkg::OP_ALLOC, 12'd4095, 1'b1, '{pfla_pkg::STATUS_OK,       12'd0,    13'd1}},
      '{pfla_pkg::OP_ALLOC, 12'd0,    1'b1, '{pfla_pkg::STATUS_OK,       12'd4095, 13'd0}},
      '{pfla_pkg::OP_ALLOC, 12'd1234, 1'b1, '{pfla_pkg::STATUS_EMPTY,    12'd0,    13'd0}},
      '{pfla_pkg::OP_FREE,  12'd4095, 1'b1, '{pfla_pkg::STATUS_OK,       12'd0,    13'd1}},
      '{pfla_pkg::OP_FREE,  12'hAAA,  1'b0, '{pfla_pkg::STATUS_OK,       12'd0,    13'd0}},
      '{pfla_pkg::OP_FREE,  12'h555,  1'b0, '{pfla_pkg::STATUS_OK,       12'd0,    13'd0}},
      '{pfla_pkg::OP_FREE,  12'd0,    1'b0, '{pfla_pkg::STATUS_OK,       12'd0,    13'd0}},
      '{pfla_pkg::OP_FREE,  12'hAAA,  1'b0, '{pfla_pkg::STATUS_OK,       12'd0,    13'd0}},
      '{pfla_pkg::OP_ALLOC, 12'hAAA,  1'b0, '{pfla_pkg::STATUS_OK,       12'd0,    13'd0}},
      '{pfla_pkg::OP_ALLOC, 12'h555,  1'b0, '{pfla_pkg::STATUS_OK,       12'd0,    13'd0}},
      '{pfla_pkg::OP_FREE,  12'd4095, 1'b0, '{pfla_pkg::STATUS_OK,       12'd0,    13'd0}},
      '{pfla_pkg::OP_FREE,  12'd1,    1'b0, '{pfla_pkg::STATUS_OK,       12'd0,    13'd0}},
      '{pfla_pkg::OP_ALLOC, 12'd0,    1'b0, '{pfla_pkg::STATUS_OK,       12'd0,    13'd0}}
   };

   // Apply one operation to the shadow state and return the response it yields
   function automatic alloc_rsp_type apply_page_op(pfla_pkg::opcode_type op,
                                                   logic [IdxWidth-1:0] idx);
      alloc_rsp_type r;
      r.status       = pfla_pkg::STATUS_OK;
      r.granted_page = '0;
      if (op == pfla_pkg::OP_ALLOC) begin
         if (free_total == 0) begin
            r.status = pfla_pkg::STATUS_EMPTY;
         end else begin
            r.granted_page = list_slots[list_head];
            list_head      = (list_head == NUM_PAGES - 1) ? 0 : list_head + 1;
            free_total--;
            page_held[r.granted_page] = 1'b1;
         end
      end else begin
         if (int'(idx) >= NUM_PAGES || !page_held[idx]) begin
            r.status = pfla_pkg::STATUS_NOT_HELD;
         end else begin
            page_held[idx]        = 1'b0;
            list_slots[list_tail] = idx;
            list_tail             = (list_tail == NUM_PAGES - 1) ? 0 : list_tail + 1;
            free_total++;
         end
      end
      r.free_pages = free_total[CountWidth-1:0];
      return r;
   endfunction

   // Present one request, hold it until taken, then record its outcome
   task automatic send_op(input pfla_pkg::opcode_type op, input logic [IdxWidth-1:0] idx,
                          input bit typed, input alloc_rsp_type typed_rsp);
      alloc_rsp_type predicted;
      int            gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.opcode     <= op;
      req_ch.page_index <= idx;
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_page_op(op, idx);
      pending_outcomes.push_back(typed ? typed_rsp : predicted);
   endtask

   function automatic logic [IdxWidth-1:0] pick_held_page();
      logic [IdxWidth-1:0] idx;
      do idx = $urandom_range(0, NUM_PAGES - 1); while (!page_held[idx]);
      return idx;
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Response side: stall in random bursts unless quiet
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 4);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Check each response against the oldest outcome waiting
   always @(posedge clock) begin : check_rsp
      alloc_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response status %0d page %0d free %0d", $time,
                     rsp_ch.status, rsp_ch.granted_page, rsp_ch.free_pages);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_ch.status !== want.status) begin
               mismatch_count++;
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_ch.status);
            end
            if (rsp_ch.granted_page !== want.granted_page) begin
               mismatch_count++;
               $display("%0t: granted_page expected %0d actual %0d", $time,
                        want.granted_page, rsp_ch.granted_page);
            end
            if (rsp_ch.free_pages !== want.free_pages) begin
               mismatch_count++;
               $display("%0t: free_pages expected %0d actual %0d", $time,
                        want.free_pages, rsp_ch.free_pages);
            end
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      alloc_rsp_type       none;
      logic [IdxWidth-1:0] idx;
      int                  pick;
      int                  start;
      int                  stride;
      int                  drain;
      int                  freed;
      none              = '0;
      list_head         = 0;
      list_tail         = 0;
      free_total        = 0;
      foreach (page_held[i]) page_held[i] = 1'b1;
      foreach (list_slots[i]) list_slots[i] = '0;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.opcode     <= pfla_pkg::OP_ALLOC;
      req_ch.page_index <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      quiet = 1'b0;

      // Directed rows
      foreach (directed_rows[i])
         send_op(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].typed,
                 directed_rows[i].rsp);

      // Random mix: mostly allocates and frees of held pages, some double frees
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            send_op(pfla_pkg::OP_ALLOC, IdxWidth'($urandom), 1'b0, none);
         end else if (pick < 85) begin
            send_op(pfla_pkg::OP_FREE, pick_held_page(), 1'b0, none);
         end else if (pick < 95 && free_total > 0) begin
            idx = list_slots[(list_head + $urandom_range(0, free_total - 1)) % NUM_PAGES];
            send_op(pfla_pkg::OP_FREE, idx, 1'b0, none);
         end else begin
            send_op(pfla_pkg::OP_FREE, IdxWidth'($urandom), 1'b0, none);
         end
      end

      // Final pass without idling: free a batch of held pages, then drain past empty
      quiet  = 1'b1;
      start  = $urandom_range(0, NUM_PAGES - 1);
      stride = 2 * $urandom_range(0, NUM_PAGES / 2 - 1) + 1;
      freed  = 0;
      for (int i = 0; i < NUM_PAGES && freed < FINAL_FREES; i++) begin
         idx = IdxWidth'((start + i * stride) % NUM_PAGES);
         if (page_held[idx]) begin
            send_op(pfla_pkg::OP_FREE, idx, 1'b0, none);
            freed++;
         end
      end
      send_op(pfla_pkg::OP_FREE, IdxWidth'($urandom), 1'b0, none);
      drain = free_total + 1;
      for (int i = 0; i < drain; i++)
         send_op(pfla_pkg::OP_ALLOC, IdxWidth'($urandom), 1'b0, none);
      for (int i = 0; i < 8; i++) begin
         send_op(pfla_pkg::OP_FREE, pick_held_page(), 1'b0, none);
         send_op(pfla_pkg::OP_ALLOC, IdxWidth'($urandom), 1'b0, none);
      end
      req_ch.valid <= 1'b0;

      // Wait for the last responses, then wait on for any stray response
      while (pending_outcomes.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Timeout
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
